// ===== sv/seven_segment_scan_controller_macros.svh =====
// assertion helpers used by the engine
`ifndef SEVEN_SEGMENT_SCAN_CONTROLLER_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_CONTROLLER_MACROS_SVH

// same-cycle implication, held off during reset
`define SSSC_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("sssc assertion failed");

// next-cycle implication, held off during reset
`define SSSC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("sssc assertion failed");

`endif

// ===== sv/sssc_pkg.sv =====
package sssc_pkg;

    // geometry of the display
    localparam int MAX_DIGITS = 4;
    localparam int SEGMENTS   = 8;
    localparam int SCAN_W     = $clog2(SEGMENTS);
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [7:0] SEG_DP = 8'h80;

    // register reset values
    localparam logic [2:0]  DIGITS_USED_RST = 3'd4;
    localparam logic        LEADING_RST     = 1'b0;
    localparam logic [15:0] REFRESH_RST     = 16'd2000;
    localparam logic [15:0] OFF_WAIT_RST    = 16'd0;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_NUMBER  = 2'd1,
        ERR_DECIMAL = 2'd2
    } err_code_t;

    typedef enum logic {
        REQ_SET  = 1'b0,
        REQ_TICK = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        REG_DIGITS_USED = 2'd0,
        REG_LEADING     = 2'd1,
        REG_REFRESH     = 2'd2,
        REG_OFF_WAIT    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0]  digits_used;
        logic        allow_leading_zeroes;
        logic [15:0] refresh_ticks;
        logic [15:0] gap_ticks;
    } cfg_t;

    // input stage contents: thousands digit already split off
    typedef struct packed {
        logic       req_type;
        logic       over;
        logic [3:0] thousands;
        logic [9:0] rest;
        logic [7:0] decimal_pos;
    } stage_t;

    // segment font, a..g in bits 0..6
    function automatic logic [7:0] seg_font(input logic [3:0] d);
        logic [7:0] code;
        unique case (d)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/sssc_if.sv =====
// item channel
interface sssc_item_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] number;
    logic [7:0]  decimal_pos;

    modport source (output valid, req_type, number, decimal_pos, input ready);
    modport sink   (input valid, req_type, number, decimal_pos, output ready);
endinterface

// result channel
interface sssc_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] segment_lines;
    logic [3:0] digit_lines;
    logic [1:0] error_code;

    modport source (output valid, segment_lines, digit_lines, error_code, input ready);
    modport sink   (input valid, segment_lines, digit_lines, error_code, output ready);
endinterface

// ===== sv/seven_segment_scan_controller.sv =====
// Seven-segment scan controller for up to four digits, multiplexed one segment at a
// time. Each transaction on the item channel yields exactly one transaction on the
// result channel: a set-number item loads new digit codes (error code 1 if the number
// does not fit the configured digit count, 2 if the decimal position is out of range),
// a tick item advances the scan timer; the lines shown always reflect the state after
// the item. Throughput is one item per clock while results are taken; each item
// passes an input register that splits off the thousands digit and then a result
// register that holds the rest of the decode and the scan update. While a result
// waits, the input register still takes one more item, after which input ready
// stays low until the result is taken. Registers sit on an APB port at byte addresses
// 0x0 digits_used, 0x4 allow_leading_zeroes, 0x8 refresh_ticks, 0xC gap_ticks; the
// user must write them only while the block is idle; the block does not enforce it.
module seven_segment_scan_controller
(
    input  logic                              clk,
    input  logic                              rst_n,
    sssc_item_if.sink                         item,
    sssc_result_if.source                     result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sssc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [sssc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [sssc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);

    sssc_pkg::cfg_t   cfg;
    sssc_pkg::stage_t stage;
    logic             stage_valid;
    logic             take;

    // configuration registers
    sssc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register with thousands split
    sssc_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .take        (take),
        .stage_valid (stage_valid),
        .stage       (stage)
    );

    // decode, scan state and result register
    sssc_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .stage       (stage),
        .take        (take),
        .result      (result)
    );

endmodule

// ===== sv/sssc_cfg.sv =====
module sssc_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sssc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [sssc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [sssc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output sssc_pkg::cfg_t                      cfg
);

    sssc_pkg::cfg_t   cfg_reg;
    sssc_pkg::cfg_t   cfg_next;
    sssc_pkg::cfg_reg_t sel;
    logic             wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign sel    = sssc_pkg::cfg_reg_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (sel)
                sssc_pkg::REG_DIGITS_USED: cfg_next.digits_used = pwdata[2:0];
                sssc_pkg::REG_LEADING:     cfg_next.allow_leading_zeroes = pwdata[0];
                sssc_pkg::REG_REFRESH:     cfg_next.refresh_ticks = pwdata[15:0];
                sssc_pkg::REG_OFF_WAIT:    cfg_next.gap_ticks = pwdata[15:0];
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (sel)
            sssc_pkg::REG_DIGITS_USED: prdata = {29'd0, cfg_reg.digits_used};
            sssc_pkg::REG_LEADING:     prdata = {31'd0, cfg_reg.allow_leading_zeroes};
            sssc_pkg::REG_REFRESH:     prdata = {16'd0, cfg_reg.refresh_ticks};
            sssc_pkg::REG_OFF_WAIT:    prdata = {16'd0, cfg_reg.gap_ticks};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.digits_used          <= sssc_pkg::DIGITS_USED_RST;
            cfg_reg.allow_leading_zeroes <= sssc_pkg::LEADING_RST;
            cfg_reg.refresh_ticks        <= sssc_pkg::REFRESH_RST;
            cfg_reg.gap_ticks            <= sssc_pkg::OFF_WAIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/sssc_in_stage.sv =====
module sssc_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    sssc_item_if.sink          item,
    input  logic               take,
    output logic               stage_valid,
    output sssc_pkg::stage_t   stage
);

    logic             valid_reg;
    logic             valid_next;
    sssc_pkg::stage_t data_reg;
    sssc_pkg::stage_t data_next;
    logic             accept;

    assign item.ready  = !valid_reg || take;
    assign accept      = item.valid && item.ready;
    assign stage_valid = valid_reg;
    assign stage       = data_reg;

    // thousands digit by parallel compares, valid for numbers below 10000
    always_comb
    begin
        logic [13:0] x;
        logic [13:0] sub;
        x   = item.number[13:0];
        sub = '0;
        data_next.thousands = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (x >= 14'(k * 1000))
            begin
                data_next.thousands = 4'(k);
                sub                 = 14'(k * 1000);
            end
        end
        data_next.rest        = 10'(x - sub);
        data_next.over        = item.number > 16'd9999;
        data_next.req_type    = item.req_type;
        data_next.decimal_pos = item.decimal_pos;
    end

    // occupancy of the input register
    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            data_reg <= data_next;
    end

endmodule

// ===== sv/sssc_engine.sv =====
`include "seven_segment_scan_controller_macros.svh"

module sssc_engine
(
    input  logic               clk,
    input  logic               rst_n,
    input  sssc_pkg::cfg_t     cfg,
    input  logic               stage_valid,
    input  sssc_pkg::stage_t   stage,
    output logic               take,
    sssc_result_if.source      result
);

    localparam int MD = sssc_pkg::MAX_DIGITS;
    localparam int SW = sssc_pkg::SCAN_W;

    // display state
    logic [7:0]    codes_reg [MD];
    logic [7:0]    codes_next [MD];
    logic [SW-1:0] scan_reg;
    logic [SW-1:0] scan_next;
    logic          waiting_reg;
    logic          waiting_next;
    logic [15:0]   tick_count_reg;
    logic [15:0]   tick_count_next;
    logic          lit_reg;
    logic          lit_next;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [7:0]          seg_reg;
    logic [7:0]          seg_next;
    logic [3:0]          dig_reg;
    logic [3:0]          dig_next;
    sssc_pkg::err_code_t err_reg;
    sssc_pkg::err_code_t err_next;

    // decoded number
    logic [2:0]  n_eff;
    logic [3:0]  dgt [4];
    logic        num_bad;
    logic        dp_bad;
    logic [1:0]  dp_eff;
    logic [7:0]  code_pos [4];
    logic [7:0]  new_codes [MD];
    logic        is_set;

    assign take   = stage_valid && (!out_valid_reg || result.ready);
    assign is_set = stage.req_type == sssc_pkg::REQ_SET;

    // effective digit count
    always_comb
    begin
        priority if (cfg.digits_used == 3'd0)
            n_eff = 3'd1;
        else if (cfg.digits_used > 3'(MD))
            n_eff = 3'(MD);
        else
            n_eff = cfg.digits_used;
    end

    // hundreds, tens and ones from the remainder below 1000
    always_comb
    begin
        logic [9:0] sub_h;
        logic [6:0] r2;
        logic [6:0] sub_t;
        sub_h  = '0;
        sub_t  = '0;
        dgt[3] = stage.thousands;
        dgt[2] = '0;
        dgt[1] = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (stage.rest >= 10'(k * 100))
            begin
                dgt[2] = 4'(k);
                sub_h  = 10'(k * 100);
            end
        end
        r2 = 7'(stage.rest - sub_h);
        for (int k = 1; k <= 9; k++)
        begin
            if (r2 >= 7'(k * 10))
            begin
                dgt[1] = 4'(k);
                sub_t  = 7'(k * 10);
            end
        end
        dgt[0] = 4'(r2 - sub_t);
    end

    // range checks against the digit count
    always_comb
    begin
        unique case (n_eff)
            3'd1:    num_bad = stage.over || (dgt[3] != 0) || (dgt[2] != 0) || (dgt[1] != 0);
            3'd2:    num_bad = stage.over || (dgt[3] != 0) || (dgt[2] != 0);
            3'd3:    num_bad = stage.over || (dgt[3] != 0);
            default: num_bad = stage.over;
        endcase
        dp_bad = stage.decimal_pos > ({5'd0, n_eff} - 8'd1);
        dp_eff = dp_bad ? 2'd0 : stage.decimal_pos[1:0];
    end

    // per decimal position: blanking, font and point
    always_comb
    begin
        logic zero_from;
        zero_from = 1'b1;
        for (int p = 3; p >= 0; p--)
        begin
            zero_from   = zero_from && (dgt[p] == 4'd0);
            code_pos[p] = sssc_pkg::seg_font(dgt[p]);
            if (!cfg.allow_leading_zeroes && zero_from && (2'(p) > dp_eff))
                code_pos[p] = 8'h00;
            if ((dp_eff != 2'd0) && (2'(p) == dp_eff))
                code_pos[p] = code_pos[p] | sssc_pkg::SEG_DP;
        end
    end

    // right-align onto the wired digits, leftmost digit first
    always_comb
    begin
        for (int i = 0; i < MD; i++)
        begin
            if (3'(i) < n_eff)
                new_codes[i] = code_pos[2'(n_eff - 3'd1 - 3'(i))];
            else
                new_codes[i] = 8'h00;
        end
    end

    // scan state update
    always_comb
    begin
        logic [15:0] tc1;
        logic [15:0] interval;
        codes_next      = codes_reg;
        scan_next       = scan_reg;
        waiting_next    = waiting_reg;
        tick_count_next = tick_count_reg;
        lit_next        = lit_reg;
        tc1      = (tick_count_reg == 16'hFFFF) ? tick_count_reg : tick_count_reg + 16'd1;
        interval = waiting_reg ? cfg.gap_ticks : cfg.refresh_ticks;
        if (is_set)
        begin
            if (!num_bad)
                codes_next = new_codes;
        end
        else if (tc1 < interval)
        begin
            tick_count_next = tc1;
        end
        else
        begin
            tick_count_next = '0;
            if (!waiting_reg && (cfg.gap_ticks != 16'd0))
            begin
                lit_next     = 1'b0;
                waiting_next = 1'b1;
            end
            else
            begin
                waiting_next = 1'b0;
                scan_next    = SW'(scan_reg + 1'b1);
                lit_next     = 1'b1;
            end
        end
    end

    // result from the updated state
    always_comb
    begin
        seg_next = lit_next ? (8'd1 << scan_next) : 8'd0;
        dig_next = '0;
        for (int i = 0; i < MD; i++)
            dig_next[i] = lit_next && (3'(i) < n_eff) && codes_next[i][scan_next];
        priority if (!is_set)
            err_next = sssc_pkg::ERR_OK;
        else if (num_bad)
            err_next = sssc_pkg::ERR_NUMBER;
        else if (dp_bad)
            err_next = sssc_pkg::ERR_DECIMAL;
        else
            err_next = sssc_pkg::ERR_OK;
    end

    // output register occupancy
    always_comb
    begin
        if (take)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MD; i++)
                codes_reg[i] <= 8'h00;
            scan_reg       <= '0;
            waiting_reg    <= 1'b0;
            tick_count_reg <= '0;
            lit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                codes_reg      <= codes_next;
                scan_reg       <= scan_next;
                waiting_reg    <= waiting_next;
                tick_count_reg <= tick_count_next;
                lit_reg        <= lit_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            seg_reg <= seg_next;
            dig_reg <= dig_next;
            err_reg <= err_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.segment_lines = seg_reg;
    assign result.digit_lines   = dig_reg;
    assign result.error_code    = err_reg;

    // checks
    `SSSC_ASSERT_IMPLY(a_gap_dark, clk, rst_n, waiting_reg, !lit_reg)
    `SSSC_ASSERT_IMPLY(a_one_segment, clk, rst_n, out_valid_reg, $onehot0(seg_reg))
    `SSSC_ASSERT_IMPLY(a_digits_need_seg, clk, rst_n, out_valid_reg && (dig_reg != 4'd0),
        seg_reg != 8'd0)
    `SSSC_ASSERT_IMPLY(a_gap_starts_clean, clk, rst_n, $rose(waiting_reg),
        tick_count_reg == 16'd0)

endmodule

// ===== tb/sv/seven_segment_scan_controller_tb.sv =====
module seven_segment_scan_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [7:0] POINT_MASK = 8'h80;

    // glyphs for 0..9, a..g in bits 0..6
    localparam logic [7:0] DIGIT_GLYPHS [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct packed {
        logic [7:0]          seg;
        logic [3:0]          digits;
        sssc_pkg::err_code_t err;
    } display_lines_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [sssc_pkg::CFG_ADDR_W-1:0] paddr;
    logic [sssc_pkg::CFG_DATA_W-1:0] pwdata;
    logic [sssc_pkg::CFG_DATA_W-1:0] prdata;
    logic pready;

    sssc_item_if   item_ch();
    sssc_result_if result_ch();

    seven_segment_scan_controller DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // display model state and register shadow
    sssc_pkg::cfg_t shadow_cfg;
    logic [7:0] shown_codes [sssc_pkg::MAX_DIGITS];
    logic [2:0] scan_pos;
    logic       gap_active;
    logic [15:0] tick_total;
    logic       segment_lit;

    display_lines_t expected_lines [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // digit count as the block uses it
    function automatic int active_digits();
        int n;
        n = shadow_cfg.digits_used;
        if (n < 1)
            n = 1;
        if (n > sssc_pkg::MAX_DIGITS)
            n = sssc_pkg::MAX_DIGITS;
        return n;
    endfunction

    // largest number that fits in n digits
    function automatic int digit_limit(input int n);
        int v;
        v = 1;
        repeat (n) v = v * 10;
        return v - 1;
    endfunction

    // applies one item to the display model, returns the lines it shows afterwards
    function automatic display_lines_t predict_display(input sssc_pkg::req_t kind,
                                                       input logic [15:0] num,
                                                       input logic [7:0] point);
        display_lines_t res;
        int n;
        int pos;
        int rem;
        bit blanking;
        bit step_scan;
        logic [3:0] dig [sssc_pkg::MAX_DIGITS];
        res.seg    = 8'h00;
        res.digits = 4'h0;
        res.err    = sssc_pkg::ERR_OK;
        n = active_digits();
        if (kind == sssc_pkg::REQ_SET)
        begin
            if (int'(num) > digit_limit(n))
                res.err = sssc_pkg::ERR_NUMBER;
            else
            begin
                pos = point;
                if (pos > n - 1)
                begin
                    res.err = sssc_pkg::ERR_DECIMAL;
                    pos = 0;
                end
                rem = num;
                for (int i = n - 1; i >= 0; i--)
                begin
                    dig[i] = 4'(rem % 10);
                    rem = rem / 10;
                end
                // blank leading zeros, but never the digit holding the point
                blanking = !shadow_cfg.allow_leading_zeroes;
                for (int i = 0; i < sssc_pkg::MAX_DIGITS; i++)
                begin
                    if (i >= n)
                        shown_codes[i] = 8'h00;
                    else if (blanking && dig[i] == 4'd0 && i != n - pos - 1)
                        shown_codes[i] = 8'h00;
                    else
                    begin
                        blanking = 1'b0;
                        shown_codes[i] = DIGIT_GLYPHS[dig[i]];
                    end
                end
                if (pos > 0)
                    shown_codes[n - pos - 1] = shown_codes[n - pos - 1] | POINT_MASK;
            end
        end
        else
        begin
            // saturating tick counter, then compare against the active interval
            if (tick_total != 16'hFFFF)
                tick_total = tick_total + 16'd1;
            if (tick_total >= (gap_active ? shadow_cfg.gap_ticks
                                          : shadow_cfg.refresh_ticks))
            begin
                tick_total = 16'd0;
                step_scan = 1'b1;
                if (gap_active)
                    gap_active = 1'b0;
                else
                begin
                    segment_lit = 1'b0;
                    if (shadow_cfg.gap_ticks != 16'd0)
                    begin
                        gap_active = 1'b1;
                        step_scan = 1'b0;
                    end
                end
                if (step_scan)
                begin
                    scan_pos = scan_pos + 3'd1;
                    segment_lit = 1'b1;
                end
            end
        end
        if (segment_lit)
        begin
            res.seg = 8'h01 << scan_pos;
            for (int i = 0; i < n; i++)
                res.digits[i] = shown_codes[i][scan_pos];
        end
        return res;
    endfunction

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : check_results
        display_lines_t exp_lines;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_lines.size() == 0)
            begin
                $display("%0t: unexpected result seg=%h digits=%h err=%0d", $time,
                         result_ch.segment_lines, result_ch.digit_lines,
                         result_ch.error_code);
                fail_count++;
            end
            else
            begin
                exp_lines = expected_lines.pop_front();
                if (result_ch.segment_lines !== exp_lines.seg)
                begin
                    $display("%0t: segment_lines expected %h got %h", $time,
                             exp_lines.seg, result_ch.segment_lines);
                    fail_count++;
                end
                if (result_ch.digit_lines !== exp_lines.digits)
                begin
                    $display("%0t: digit_lines expected %h got %h", $time,
                             exp_lines.digits, result_ch.digit_lines);
                    fail_count++;
                end
                if (result_ch.error_code !== exp_lines.err)
                begin
                    $display("%0t: error_code expected %0d got %0d", $time,
                             exp_lines.err, result_ch.error_code);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("seven_segment_scan_controller test failed");
            $finish;
        end
    end

    // one item transaction, with random idle cycles ahead of it
    task automatic send_item(input sssc_pkg::req_t kind, input logic [15:0] num,
                             input logic [7:0] point);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.req_type    <= kind;
        item_ch.number      <= num;
        item_ch.decimal_pos <= point;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        expected_lines.push_back(predict_display(kind, num, point));
    endtask

    task automatic send_tick();
        send_item(sssc_pkg::REQ_TICK, 16'($urandom), 8'($urandom));
    endtask

    // random item: mostly ticks, numbers mostly well formed
    task automatic send_random_item();
        int n;
        int pick;
        n = active_digits();
        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 99) >= 30)
            send_tick();
        else if (pick < 7)
            send_item(sssc_pkg::REQ_SET, 16'($urandom_range(0, digit_limit(n))),
                      8'($urandom_range(0, n - 1)));
        else if (pick == 7)
            send_item(sssc_pkg::REQ_SET, 16'($urandom_range(0, digit_limit(n))),
                      8'($urandom_range(0, 255)));
        else if (pick == 8)
            send_item(sssc_pkg::REQ_SET, 16'($urandom_range(0, 65535)),
                      8'($urandom_range(0, n)));
        else
            send_item(sssc_pkg::REQ_SET, 16'($urandom), 8'($urandom));
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (expected_lines.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb write: setup phase, access phase, then psel and penable dropped before returning
    task automatic write_register(input sssc_pkg::cfg_reg_t which,
                                  input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (which)
            sssc_pkg::REG_DIGITS_USED: shadow_cfg.digits_used          = value[2:0];
            sssc_pkg::REG_LEADING:     shadow_cfg.allow_leading_zeroes = value[0];
            sssc_pkg::REG_REFRESH:     shadow_cfg.refresh_ticks        = value[15:0];
            sssc_pkg::REG_OFF_WAIT:    shadow_cfg.gap_ticks            = value[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(input int digits, input int leading, input int refresh,
                             input int off_wait);
        drain_results();
        write_register(sssc_pkg::REG_DIGITS_USED, 32'(digits));
        write_register(sssc_pkg::REG_LEADING, 32'(leading));
        write_register(sssc_pkg::REG_REFRESH, 32'(refresh));
        write_register(sssc_pkg::REG_OFF_WAIT, 32'(off_wait));
    endtask

    // reset values: nothing lit until the long refresh interval runs out
    task automatic test_reset_state();
        send_item(sssc_pkg::REQ_SET, 16'd1234, 8'd1);
        send_tick();
        send_item(sssc_pkg::REQ_SET, 16'd10000, 8'd0);
    endtask

    // field extremes, errors, point handling and a full scan
    task automatic test_directed_cases();
        configure(4, 0, 0, 0);
        send_item(sssc_pkg::REQ_SET, 16'd0, 8'd0);
        send_item(sssc_pkg::REQ_SET, 16'd65535, 8'd0);
        send_item(sssc_pkg::REQ_SET, 16'd10000, 8'd3);
        send_item(sssc_pkg::REQ_SET, 16'd5, 8'd4);
        send_item(sssc_pkg::REQ_SET, 16'd5, 8'd255);
        send_item(sssc_pkg::REQ_SET, 16'd7, 8'd3);
        send_item(sssc_pkg::REQ_SET, 16'd9999, 8'd0);
        send_item(sssc_pkg::REQ_SET, 16'd1020, 8'd2);
        repeat (8) send_tick();
        // leading zeros shown
        configure(4, 1, 0, 0);
        send_item(sssc_pkg::REQ_SET, 16'd42, 8'd0);
        send_tick();
        // single digit with a blank gap
        configure(1, 1, 1, 2);
        send_item(sssc_pkg::REQ_SET, 16'd9, 8'd0);
        send_item(sssc_pkg::REQ_SET, 16'd10, 8'd0);
        send_item(sssc_pkg::REQ_SET, 16'd0, 8'd1);
        repeat (4) send_tick();
        // digit count out of range on both sides
        configure(0, 0, 0, 0);
        send_item(sssc_pkg::REQ_SET, 16'd8, 8'd0);
        send_tick();
        configure(7, 0, 0, 0);
        send_item(sssc_pkg::REQ_SET, 16'd8888, 8'd3);
        send_tick();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        repeat (4)
        begin
            configure($urandom_range(0, 7), $urandom_range(0, 1),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20)
                                                  : $urandom_range(0, 3),
                      $urandom_range(0, 1) ? 0 : $urandom_range(1, 4));
            repeat (90) send_random_item();
        end
    endtask

    // long receiver hold-off fills the block, then the sender waits it out
    task automatic test_backpressure();
        configure(4, 0, 1, 0);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_request = 60;
        repeat (40) send_random_item();
        drain_results();
        stall_pct = 30;
        repeat (20) send_random_item();
        drain_results();
    endtask

    // largest intervals, then shortened while the counter is part way through
    task automatic test_long_intervals();
        send_idle_pct = 0;
        stall_pct = 0;
        configure(4, 0, 65535, 65535);
        send_item(sssc_pkg::REQ_SET, 16'd8888, 8'd2);
        repeat (40) send_tick();
        configure(4, 0, 30, 65535);
        repeat (20) send_tick();
        configure(4, 0, 30, 10);
        repeat (40) send_tick();
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.req_type = sssc_pkg::REQ_SET;
        item_ch.number = 16'd0;
        item_ch.decimal_pos = 8'd0;
        result_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        // model state after reset
        shadow_cfg.digits_used = sssc_pkg::DIGITS_USED_RST;
        shadow_cfg.allow_leading_zeroes = sssc_pkg::LEADING_RST;
        shadow_cfg.refresh_ticks = sssc_pkg::REFRESH_RST;
        shadow_cfg.gap_ticks = sssc_pkg::OFF_WAIT_RST;
        for (int i = 0; i < sssc_pkg::MAX_DIGITS; i++)
            shown_codes[i] = 8'h00;
        scan_pos = 3'd0;
        gap_active = 1'b0;
        tick_total = 16'd0;
        segment_lit = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_cases();
        test_random_traffic(0, 0);
        test_random_traffic(46, 0);
        test_random_traffic(0, 46);
        test_random_traffic(16, 16);
        test_backpressure();
        test_long_intervals();

        drain_results();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("seven_segment_scan_controller test passed");
        else
            $display("seven_segment_scan_controller test failed");
        $finish;
    end

endmodule
